@@ src/mrfc_pkg.sv @@
package mrfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_LSB  = 16'h0001;
  localparam int unsigned MIN_FRAME_BYTES = 4;

  localparam logic [1:0] REG_FIRST_ADDR  = 2'd0;
  localparam logic [1:0] REG_SECOND_ADDR = 2'd1;
  localparam logic [1:0] REG_READ_CODE   = 2'd2;
  localparam logic [1:0] REG_WRITE_CODE  = 2'd3;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_CRC_ERROR    = 3'd1,
    ST_ADDR_UNKNOWN = 3'd2,
    ST_FUNC_UNKNOWN = 3'd3,
    ST_TOO_SHORT    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DEV_NONE   = 2'd0,
    DEV_FIRST  = 2'd1,
    DEV_SECOND = 2'd2
  } dev_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] first_addr;
    logic [7:0] second_addr;
    logic [7:0] read_code;
    logic [7:0] write_code;
  } cfg_t;

  // Everything the back end needs to judge one frame.
  typedef struct packed {
    logic        too_short;
    logic [15:0] crc;
    logic [7:0]  tail_lo;
    logic [7:0]  tail_hi;
    logic [7:0]  addr;
    logic [7:0]  func;
  } summary_t;

  typedef struct packed {
    status_t     status;
    dev_t        dev;
    kind_t       kind;
    logic [15:0] crc;
  } result_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_LSB) != 16'h0000) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/mrfc_front.sv @@
module mrfc_front #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  output logic              push_valid,
  input  logic              push_ready,
  output mrfc_pkg::summary_t push_data
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  logic [15:0]   crc;
  logic [7:0]    tail0;
  logic [7:0]    tail1;
  logic [CW-1:0] count;
  logic [7:0]    addr;
  logic [7:0]    func;

  logic [15:0]   crc_next;
  logic [CW-1:0] count_next;
  logic [7:0]    addr_next;
  logic [7:0]    func_next;
  logic          accept;

  assign s_tready = push_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    crc_next   = (count >= CW'(2)) ? mrfc_pkg::crc_fold(crc, tail0) : crc;
    count_next = (count < CW'(MAX_FRAME_BYTES)) ? count + CW'(1) : count;
    addr_next  = (count == CW'(0)) ? s_tdata : addr;
    func_next  = (count == CW'(1)) ? s_tdata : func;
  end

  assign push_valid          = accept && s_tlast;
  assign push_data.too_short = count_next < CW'(mrfc_pkg::MIN_FRAME_BYTES);
  assign push_data.crc       = crc_next;
  assign push_data.tail_lo   = tail1;
  assign push_data.tail_hi   = s_tdata;
  assign push_data.addr      = addr_next;
  assign push_data.func      = func_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= mrfc_pkg::CRC_INIT;
      tail0 <= 8'h00;
      tail1 <= 8'h00;
      count <= '0;
      addr  <= 8'h00;
      func  <= 8'h00;
    end else if (accept) begin
      if (s_tlast) begin
        crc   <= mrfc_pkg::CRC_INIT;
        tail0 <= 8'h00;
        tail1 <= 8'h00;
        count <= '0;
        addr  <= 8'h00;
        func  <= 8'h00;
      end else begin
        crc   <= crc_next;
        tail0 <= tail1;
        tail1 <= s_tdata;
        count <= count_next;
        addr  <= addr_next;
        func  <= func_next;
      end
    end
  end

endmodule

@@ src/mrfc_queue.sv @@
module mrfc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mrfc_pkg::summary_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mrfc_pkg::summary_t pop_data
);

  mrfc_pkg::summary_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ src/mrfc_back.sv @@
module mrfc_back (
  input  logic               clk,
  input  logic               rst,
  input  mrfc_pkg::cfg_t     cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  mrfc_pkg::summary_t pop_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output mrfc_pkg::result_t  result
);

  mrfc_pkg::result_t result_next;

  assign pop_ready = !m_tvalid || m_tready;

  always_comb begin
    result_next.status = mrfc_pkg::ST_OK;
    result_next.dev    = mrfc_pkg::DEV_NONE;
    result_next.kind   = mrfc_pkg::KIND_OTHER;
    result_next.crc    = pop_data.crc;
    priority if (pop_data.too_short) begin
      result_next.status = mrfc_pkg::ST_TOO_SHORT;
    end else if (pop_data.tail_lo != pop_data.crc[7:0] ||
                 pop_data.tail_hi != pop_data.crc[15:8]) begin
      result_next.status = mrfc_pkg::ST_CRC_ERROR;
    end else if (pop_data.addr == cfg.first_addr || pop_data.addr == cfg.second_addr) begin
      result_next.dev = (pop_data.addr == cfg.first_addr) ? mrfc_pkg::DEV_FIRST
                                                           : mrfc_pkg::DEV_SECOND;
      priority if (pop_data.func == cfg.read_code) begin
        result_next.kind = mrfc_pkg::KIND_READ;
      end else if (pop_data.func == cfg.write_code) begin
        result_next.kind = mrfc_pkg::KIND_WRITE;
      end else begin
        result_next.status = mrfc_pkg::ST_FUNC_UNKNOWN;
      end
    end else begin
      result_next.status = mrfc_pkg::ST_ADDR_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop_ready) begin
      m_tvalid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      result <= result_next;
    end
  end

endmodule

@@ src/modbus_rtu_frame_checker_top.sv @@
// Modbus RTU frame checker.
// Received bytes enter on the s_ channel, one byte per request, with s_tlast
// set on the final byte of a frame. The block keeps a CRC-16 (0xFFFF start,
// reflected polynomial 0xA001) over all bytes but the last two and compares
// those two with it, low byte first. It then matches the first byte against
// the two device addresses and the second byte against the read and write
// function codes. Each frame yields exactly one status request on the m_
// channel; no other byte yields anything.
// A byte is taken every cycle while the queue has room. The status of
// a frame goes from its final byte through a two-entry frame queue and an
// output register to m_tvalid. When the receiver stalls, finished frames
// collect in the queue, and s_tready drops only when the queue is full.
// Reset clears the frame state, empties the queue and drops m_tvalid; the
// registers return to addresses 1 and 2 and function codes 3 and 6. The
// registers are written over the APB port; the user must write them only
// while no frame is in flight, and the block does not enforce this.
module modbus_rtu_frame_checker_top #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] frame_status, [4:3] device_index, [6:5] function_kind,
  // [22:7] computed_crc, [23] zero
  output logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mrfc_pkg::cfg_t     cfg;
  mrfc_pkg::summary_t push_data;
  mrfc_pkg::summary_t pop_data;
  mrfc_pkg::result_t  result;
  logic               push_valid;
  logic               push_ready;
  logic               pop_valid;
  logic               pop_ready;
  logic [1:0]         reg_index;
  logic [7:0]         read_byte;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_addr  <= 8'd1;
      cfg.second_addr <= 8'd2;
      cfg.read_code   <= 8'd3;
      cfg.write_code  <= 8'd6;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        mrfc_pkg::REG_FIRST_ADDR:  cfg.first_addr  <= pwdata[7:0];
        mrfc_pkg::REG_SECOND_ADDR: cfg.second_addr <= pwdata[7:0];
        mrfc_pkg::REG_READ_CODE:   cfg.read_code   <= pwdata[7:0];
        mrfc_pkg::REG_WRITE_CODE:  cfg.write_code  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      mrfc_pkg::REG_FIRST_ADDR:  read_byte = cfg.first_addr;
      mrfc_pkg::REG_SECOND_ADDR: read_byte = cfg.second_addr;
      mrfc_pkg::REG_READ_CODE:   read_byte = cfg.read_code;
      mrfc_pkg::REG_WRITE_CODE:  read_byte = cfg.write_code;
      default:                   read_byte = 8'h00;
    endcase
  end

  assign prdata = {24'h000000, read_byte};

  mrfc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mrfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mrfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (result)
  );

  assign m_tdata = {1'b0, result.crc, result.kind, result.dev, result.status};

endmodule

@@ src/mrfc_checker.sv @@
module mrfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        pready
);

  // A held result must not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Any status other than ok leaves the function kind at other.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != mrfc_pkg::ST_OK |-> m_tdata[6:5] == mrfc_pkg::KIND_OTHER)
    else $error("function kind set on a failed frame");

  // Too short, CRC error and unknown address name no device.
  a_dev: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == mrfc_pkg::ST_CRC_ERROR ||
                 m_tdata[2:0] == mrfc_pkg::ST_ADDR_UNKNOWN ||
                 m_tdata[2:0] == mrfc_pkg::ST_TOO_SHORT)
    |-> m_tdata[4:3] == mrfc_pkg::DEV_NONE)
    else $error("device named on a frame without a valid address");

  // A good frame always names a device and a known function.
  a_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == mrfc_pkg::ST_OK
    |-> m_tdata[4:3] != mrfc_pkg::DEV_NONE && m_tdata[6:5] != mrfc_pkg::KIND_OTHER)
    else $error("good frame without device or function");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind modbus_rtu_frame_checker_top mrfc_checker u_mrfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);
